// ----- rtl/wft_pkg.sv -----
package wft_pkg;

    // table geometry
    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_WORD_LEN = 41;

    // derived widths
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W = $clog2(MAX_WORD_LEN);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

    // word delimiters
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // result beat
    typedef struct packed {
        logic [5:0]  entry_index;
        logic [31:0] word_count;
        logic        newly_added;
        logic        table_full;
        logic        word_truncated;
        logic [6:0]  distinct_words;
        logic [31:0] total_occurrences;
        logic        stream_done;
    } t_out;

    // one character of the word under search, shifted from cell to cell;
    // the search outcome rides along with the last character
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] target;
        logic             found;
        logic             added;
        logic [IDX_W-1:0] slot;
        logic [31:0]      count;
    } t_beat;

endpackage

// ----- rtl/wft_cell.sv -----
module wft_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [wft_pkg::IDX_W-1:0] i_index,
    input  wft_pkg::t_beat            i_beat,
    output wft_pkg::t_beat            o_beat
);

    // stored key, its length and count for this slot
    logic [7:0]                r_key [wft_pkg::MAX_WORD_LEN];
    logic [wft_pkg::LEN_W-1:0] r_len;
    logic [31:0]               r_count;

    wft_pkg::t_beat            r_a;
    logic [7:0]                r_rdata;
    logic                      r_match;
    wft_pkg::t_beat            r_out;

    logic                      w_self_in;
    logic                      w_self_a;
    logic                      w_valid_a;
    logic                      w_eq;
    logic                      n_match;
    logic                      w_hit;
    logic                      w_claim;
    wft_pkg::t_beat            n_beat;
    logic [wft_pkg::LEN_W-1:0] n_len;
    logic [31:0]               n_count;

    assign w_self_in = (wft_pkg::CNT_W'(i_index) == i_beat.target);
    assign w_self_a  = (wft_pkg::CNT_W'(i_index) == r_a.target);
    assign w_valid_a = (wft_pkg::CNT_W'(i_index) < r_a.target);

    // key store: the free slot takes the word as it passes, every slot reads
    always_ff @(posedge i_clk) begin
        if (i_beat.vld) begin
            if (w_self_in) begin
                r_key[i_beat.pos] <= i_beat.data;
            end
            r_rdata <= r_key[i_beat.pos];
        end
    end

    // compare and update on the second stage
    always_comb begin
        w_eq    = (r_rdata == r_a.data);
        n_match = (r_a.pos == '0) ? w_eq : (r_match & w_eq);
        w_hit   = r_a.vld && r_a.last && w_valid_a && n_match && (r_len == r_a.len)
                  && !r_a.found;
        w_claim = r_a.vld && r_a.last && w_self_a && !r_a.found;
        n_beat  = r_a;
        n_len   = r_len;
        n_count = r_count;
        if (w_hit) begin
            n_count      = (r_count == wft_pkg::COUNT_MAX) ? r_count : r_count + 32'd1;
            n_beat.found = 1'b1;
            n_beat.slot  = i_index;
            n_beat.count = n_count;
        end
        if (w_claim) begin
            n_len        = r_a.len;
            n_count      = 32'd1;
            n_beat.added = 1'b1;
            n_beat.slot  = i_index;
            n_beat.count = 32'd1;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld   <= 1'b0;
            r_out.vld <= 1'b0;
        end else begin
            r_a   <= i_beat;
            r_out <= n_beat;
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        if (r_a.vld) begin
            r_match <= n_match;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

    assign o_beat = r_out;

endmodule

// ----- rtl/word_frequency_table_unit.sv -----
// word frequency counter over a byte stream
//
// input: one text byte per beat, taken when start is high and busy is low.
// space and newline end a word; empty words give nothing. end_of_text on a
// beat finishes any word still pending after that byte.
// output: one result per finished word, shown for a single cycle with
// o_strobe high; the receiver cannot stall and must take it then.
// rate: a word character takes one cycle. a finished word keeps busy high
// while its stored bytes are read out of the pending buffer and shift
// through a row of TABLE_DEPTH slot cells, two register stages per cell
// (key read, then compare and update). the result strobe comes in the cycle
// busy falls, so the next byte can be taken at once.
// the free slot picks the word up as it passes, so a new word is stored in
// the same pass that searches for it.
// reset clears the pending word, the entry count and the running total;
// stored keys and counts need no clearing, only slots in use are compared.
module word_frequency_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  wft_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_strobe,
    output wft_pkg::t_out o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_WAIT
    } t_state;

    t_state                    r_state;
    logic [7:0]                r_pend [wft_pkg::MAX_WORD_LEN];
    logic [wft_pkg::LEN_W-1:0] r_plen;
    logic                      r_pover;
    logic [wft_pkg::LEN_W-1:0] r_word_len;
    logic                      r_word_over;
    logic                      r_word_done;
    logic [wft_pkg::POS_W-1:0] r_rd_pos;
    logic [wft_pkg::POS_W-1:0] r_rd_pos_q;
    logic                      r_rd_vld;
    logic                      r_rd_last;
    logic [7:0]                r_rd_data;
    logic [wft_pkg::CNT_W-1:0] r_used;
    logic [31:0]               r_sum;
    logic                      r_strobe;
    wft_pkg::t_out             r_out;

    logic                      w_accept;
    logic                      w_delim;
    logic                      w_fits;
    logic                      w_finish;
    logic                      w_rd_last;
    logic [wft_pkg::LEN_W-1:0] n_plen;
    logic                      n_pover;
    logic                      w_end;
    logic                      w_full;
    logic [wft_pkg::CNT_W-1:0] n_used;
    logic [31:0]               n_sum;

    wft_pkg::t_beat            w_chain [wft_pkg::TABLE_DEPTH + 1];

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // word assembly
    always_comb begin
        w_delim  = (i_in.text_byte == wft_pkg::CHAR_SPACE) ||
                   (i_in.text_byte == wft_pkg::CHAR_NEWLINE);
        w_fits   = (r_plen < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN));
        n_plen   = (!w_delim && w_fits) ? r_plen + wft_pkg::LEN_W'(1) : r_plen;
        n_pover  = r_pover | (!w_delim && !w_fits);
        w_finish = w_accept && ((w_delim && (r_plen != '0)) ||
                                (!w_delim && i_in.end_of_text));
        w_rd_last = (wft_pkg::LEN_W'(r_rd_pos) == r_word_len - wft_pkg::LEN_W'(1));
    end

    // pending word buffer
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_delim && w_fits) begin
            r_pend[r_plen[wft_pkg::POS_W-1:0]] <= i_in.text_byte;
        end
        if (r_state == S_FEED) begin
            r_rd_data <= r_pend[r_rd_pos];
        end
    end

    // head of the cell row
    always_comb begin
        w_chain[0]        = '0;
        w_chain[0].vld    = r_rd_vld;
        w_chain[0].last   = r_rd_last;
        w_chain[0].pos    = r_rd_pos_q;
        w_chain[0].data   = r_rd_data;
        w_chain[0].len    = r_word_len;
        w_chain[0].target = r_used;
    end

    // row of slot cells
    for (genvar g = 0; g < wft_pkg::TABLE_DEPTH; g++) begin : g_cell
        wft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (wft_pkg::IDX_W'(g)),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g + 1])
        );
    end

    // outcome at the tail of the row
    always_comb begin
        w_end  = w_chain[wft_pkg::TABLE_DEPTH].vld && w_chain[wft_pkg::TABLE_DEPTH].last;
        w_full = !w_chain[wft_pkg::TABLE_DEPTH].found && !w_chain[wft_pkg::TABLE_DEPTH].added;
        n_used = r_used + wft_pkg::CNT_W'(w_chain[wft_pkg::TABLE_DEPTH].added);
        n_sum  = (!w_full && (r_sum != wft_pkg::COUNT_MAX)) ? r_sum + 32'd1 : r_sum;
    end

    // sequencer, totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_plen   <= '0;
            r_pover  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_used   <= '0;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_finish) begin
                        r_plen      <= '0;
                        r_pover     <= 1'b0;
                        r_word_len  <= n_plen;
                        r_word_over <= n_pover;
                        r_word_done <= i_in.end_of_text;
                        r_rd_pos    <= '0;
                        r_state     <= S_FEED;
                    end else if (w_accept) begin
                        r_plen  <= n_plen;
                        r_pover <= n_pover;
                    end
                end
                S_FEED: begin
                    r_rd_vld   <= 1'b1;
                    r_rd_last  <= w_rd_last;
                    r_rd_pos_q <= r_rd_pos;
                    r_rd_pos   <= r_rd_pos + wft_pkg::POS_W'(1);
                    if (w_rd_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_end) begin
                        r_used                  <= n_used;
                        r_sum                   <= n_sum;
                        r_strobe                <= 1'b1;
                        r_out.entry_index       <= 6'(w_chain[wft_pkg::TABLE_DEPTH].slot);
                        r_out.word_count        <= w_chain[wft_pkg::TABLE_DEPTH].count;
                        r_out.newly_added       <= w_chain[wft_pkg::TABLE_DEPTH].added;
                        r_out.table_full        <= w_full;
                        r_out.word_truncated    <= r_word_over;
                        r_out.distinct_words    <= 7'(n_used);
                        r_out.total_occurrences <= n_sum;
                        r_out.stream_done       <= r_word_done;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // busy only drops together with a result
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result");

    // a result is never directly followed by another result
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // a new entry starts at one and is never also a dropped word
    a_added_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.newly_added) |-> (o_out.word_count == 32'd1 && !o_out.table_full))
        else $error("inconsistent new entry result");

    // a word is dropped only with every slot in use
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.table_full) |->
            (o_out.distinct_words == 7'(wft_pkg::TABLE_DEPTH) && o_out.word_count == 32'd0))
        else $error("word dropped while slots remain");

endmodule
